// ----- hdl/gnt_pkg.sv -----
package gnt_pkg;

    // Line counter width and result queue sizing
    localparam int LINE_BITS  = 16;
    localparam int RES_MAX    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int RES_CW     = $clog2(RES_MAX + 1);

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_STRING,
        MODE_REGEX,
        MODE_IDENT,
        MODE_COMMENT,
        MODE_DASH
    } t_mode;

    typedef enum logic [3:0] {
        KIND_OR,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_PLUS,
        KIND_STAR,
        KIND_SEMI,
        KIND_OPT,
        KIND_ARROW,
        KIND_TEXT,
        KIND_STR_END,
        KIND_RGX_END,
        KIND_ID_END,
        KIND_ERROR,
        KIND_END
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_BAD_CHAR,
        ERR_DASH,
        ERR_NEWLINE
    } t_err;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       byte_present;
        logic       final_item;
    } t_item;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           text;
        logic [LINE_BITS-1:0] line;
        t_err                 err;
        logic                 last;
    } t_result;

    typedef struct packed {
        t_result [RES_MAX-1:0] res;
        logic [RES_CW-1:0]     cnt;
    } t_res_set;

endpackage

// ----- hdl/gnt_scan.sv -----
module gnt_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gnt_pkg::t_item    i_item,
    input  logic              i_advance,
    output gnt_pkg::t_res_set o_set
);
    import gnt_pkg::*;

    t_mode                r_mode;
    t_mode                n_mode;
    logic [LINE_BITS-1:0] r_line;
    logic [LINE_BITS-1:0] n_line;
    t_res_set             res_set;
    logic                 do_normal;
    logic [7:0]           c;
    logic [7:0]           end_char;
    t_kind                end_kind;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER || b == CH_QMARK;
    endfunction

    // Append one result, drop it once the set is full
    function automatic t_res_set push(input t_res_set s, input t_kind k,
                                      input logic [7:0] b, input t_err e,
                                      input logic [LINE_BITS-1:0] ln);
        t_res_set o;
        o = s;
        if (s.cnt < RES_CW'(RES_MAX)) begin
            o.res[s.cnt[1:0]] = '{kind: k, text: b, line: ln, err: e, last: 1'b0};
            o.cnt = s.cnt + 1'b1;
        end
        return o;
    endfunction

    assign c = i_item.source_byte;

    // Classify the byte against the current mode and build the result set
    always_comb begin
        res_set   = '0;
        n_mode    = r_mode;
        n_line    = r_line;
        do_normal = 1'b0;
        end_char  = (r_mode == MODE_STRING) ? CH_QUOTE : CH_SLASH;
        end_kind  = (r_mode == MODE_STRING) ? KIND_STR_END : KIND_RGX_END;

        if (i_item.byte_present) begin
            case (r_mode)
                MODE_STRING, MODE_REGEX: begin
                    if (c == end_char || c == CH_NUL) begin
                        res_set = push(res_set, end_kind, 8'h00, ERR_NONE, n_line);
                        n_mode  = MODE_NORMAL;
                    end else if (c == CH_LF) begin
                        res_set = push(res_set, KIND_ERROR, 8'h00, ERR_NEWLINE, n_line);
                        if (n_line != '1) begin
                            n_line = n_line + 1'b1;
                        end
                        res_set = push(res_set, end_kind, 8'h00, ERR_NONE, n_line);
                        n_mode  = MODE_NORMAL;
                    end else begin
                        res_set = push(res_set, KIND_TEXT, c, ERR_NONE, n_line);
                    end
                end
                MODE_IDENT: begin
                    if (is_ident_char(c)) begin
                        res_set = push(res_set, KIND_TEXT, c, ERR_NONE, n_line);
                    end else begin
                        res_set   = push(res_set, KIND_ID_END, 8'h00, ERR_NONE, n_line);
                        do_normal = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        n_mode = MODE_NORMAL;
                        if (n_line != '1) begin
                            n_line = n_line + 1'b1;
                        end
                    end
                end
                MODE_DASH: begin
                    n_mode = MODE_NORMAL;
                    if (c == CH_GT) begin
                        res_set = push(res_set, KIND_ARROW, 8'h00, ERR_NONE, n_line);
                    end else begin
                        res_set   = push(res_set, KIND_ERROR, 8'h00, ERR_DASH, n_line);
                        do_normal = 1'b1;
                    end
                end
                default: begin
                    do_normal = 1'b1;
                end
            endcase
        end

        // Handle the byte in normal mode
        if (do_normal) begin
            n_mode = MODE_NORMAL;
            case (c)
                CH_LF: begin
                    if (n_line != '1) begin
                        n_line = n_line + 1'b1;
                    end
                end
                CH_SPACE, CH_TAB: ;
                CH_BAR:    res_set = push(res_set, KIND_OR, 8'h00, ERR_NONE, n_line);
                CH_LPAREN: res_set = push(res_set, KIND_LPAREN, 8'h00, ERR_NONE, n_line);
                CH_RPAREN: res_set = push(res_set, KIND_RPAREN, 8'h00, ERR_NONE, n_line);
                CH_PLUS:   res_set = push(res_set, KIND_PLUS, 8'h00, ERR_NONE, n_line);
                CH_STAR:   res_set = push(res_set, KIND_STAR, 8'h00, ERR_NONE, n_line);
                CH_SEMI:   res_set = push(res_set, KIND_SEMI, 8'h00, ERR_NONE, n_line);
                CH_QMARK:  res_set = push(res_set, KIND_OPT, 8'h00, ERR_NONE, n_line);
                CH_QUOTE:  n_mode = MODE_STRING;
                CH_SLASH:  n_mode = MODE_REGEX;
                CH_DASH:   n_mode = MODE_DASH;
                CH_HASH, CH_EQ: n_mode = MODE_COMMENT;
                default: begin
                    if (is_letter(c)) begin
                        res_set = push(res_set, KIND_TEXT, c, ERR_NONE, n_line);
                        n_mode  = MODE_IDENT;
                    end else begin
                        res_set = push(res_set, KIND_ERROR, 8'h00, ERR_BAD_CHAR, n_line);
                    end
                end
            endcase
        end

        // Close the source: end token (or dash error) for an open construct if the set has room, then END
        if (i_item.final_item) begin
            if (res_set.cnt < RES_CW'(RES_MAX - 1)) begin
                case (n_mode)
                    MODE_STRING: res_set = push(res_set, KIND_STR_END, 8'h00, ERR_NONE, n_line);
                    MODE_REGEX:  res_set = push(res_set, KIND_RGX_END, 8'h00, ERR_NONE, n_line);
                    MODE_IDENT:  res_set = push(res_set, KIND_ID_END, 8'h00, ERR_NONE, n_line);
                    MODE_DASH:   res_set = push(res_set, KIND_ERROR, 8'h00, ERR_DASH, n_line);
                    default: ;
                endcase
            end
            res_set = push(res_set, KIND_END, 8'h00, ERR_NONE, n_line);
            n_mode  = MODE_NORMAL;
            n_line  = '0;
        end

        // Flag the last result of the item
        if (res_set.cnt != '0) begin
            res_set.res[2'(res_set.cnt - 1'b1)].last = 1'b1;
        end
    end

    assign o_set = res_set;

    // Advance scan state once the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_line <= '0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_line <= n_line;
        end
    end

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.final_item) |=> (r_mode == MODE_NORMAL && r_line == '0))
        else $error("scan state not cleared after final item");

    a_final_has_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.final_item |-> (res_set.cnt != '0))
        else $error("final item produced no END");

    a_comment_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.byte_present && !i_item.final_item
         && r_mode == MODE_COMMENT && i_item.source_byte != CH_LF)
        |=> (r_mode == MODE_COMMENT && $stable(r_line)))
        else $error("comment left without newline");

endmodule

// ----- hdl/gnt_fifo.sv -----
module gnt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  gnt_pkg::t_res_set i_wr_set,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output gnt_pkg::t_result  o_head
);
    import gnt_pkg::*;

    t_result              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_CW-1:0]   wr_n;
    logic                 pop;

    assign wr_n    = i_wr_en ? FIFO_CW'(i_wr_set.cnt) : '0;
    assign o_room  = r_count <= FIFO_CW'(FIFO_DEPTH - RES_MAX);
    assign o_valid = r_count != '0;
    assign pop     = o_valid && i_ready;
    assign o_head  = mem[r_rd_ptr];

    // Store the new results in order behind the tail
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (i_wr_en && RES_CW'(k) < i_wr_set.cnt) begin
                mem[r_wr_ptr + FIFO_AW'(k)] <= i_wr_set.res[k];
            end
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(wr_n);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_count  <= r_count + wr_n - FIFO_CW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue over depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> (({1'b0, r_count} + {1'b0, wr_n}) <= (FIFO_CW + 1)'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && !pop) |=> (r_count == $past(r_count) + $past(wr_n)))
        else $error("result queue count mismatch");

endmodule

// ----- hdl/grammar_notation_tokenizer.sv -----
// Streaming tokenizer for a small grammar notation: one source byte per input word,
// tokens out as words carrying kind, text byte, line number, error code and a flag on
// the last token of each byte. A byte is taken every cycle while each byte yields at most
// one token and the output is ready; a byte that yields two or three tokens (an identifier
// end or dangling dash followed by another token, a newline inside a string, a final byte
// that adds END to other tokens) holds up the input, since the four-entry result queue
// issues one word per cycle while the output is ready and takes a byte only while it holds
// at most one word. Each input word is registered before its tokens enter the queue.
// Scan mode and line count reset after each final word, so sources can follow directly.
module grammar_notation_tokenizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_source_byte,
    input  logic                          i_byte_present,
    input  logic                          i_final_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [3:0]                    o_token_kind,
    output logic [7:0]                    o_text_byte,
    output logic [gnt_pkg::LINE_BITS-1:0] o_line_number,
    output logic [1:0]                    o_error_code,
    output logic                          o_run_last
);
    import gnt_pkg::*;

    t_item    r_item;
    logic     r_in_valid;
    logic     room;
    logic     consume;
    t_res_set res_set;
    t_result  head;

    assign consume    = r_in_valid && room;
    assign o_in_ready = !r_in_valid || consume;

    // Hold the input word until the queue can take its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{source_byte: i_source_byte, byte_present: i_byte_present,
                        final_item: i_final_item};
        end
    end

    gnt_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_item),
        .i_advance (consume),
        .o_set     (res_set)
    );

    gnt_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (consume),
        .i_wr_set (res_set),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_head   (head)
    );

    assign o_token_kind  = head.kind;
    assign o_text_byte   = head.text;
    assign o_line_number = head.line;
    assign o_error_code  = head.err;
    assign o_run_last    = head.last;

endmodule
